FILE: sv/rq_pkg.sv
// ----------------------------------------------------------------------------
// rq_pkg: shared types and constants for the ready queue
// Entry layout, operation and status codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rq_pkg;

   // default number of queue slots
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int ID_W    = 16;
   localparam int PRIO_W  = 8;
   localparam int TAG_W   = 16;
   localparam int ENTRY_W = ID_W + PRIO_W + TAG_W;
   localparam int STAT_W  = 2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   // one stored job, id in the low bits
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   // source of the pending result
   typedef enum logic [1:0] {
      PEND_NEW  = 2'd0,
      PEND_FULL = 2'd1,
      PEND_NONE = 2'd2,
      PEND_BEST = 2'd3
   } pend_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DECIDE = 3'd1,
      ST_SCAN   = 3'd2,
      ST_SHIFT  = 3'd3,
      ST_DONE   = 3'd4
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic     load_req;
      logic     ins_write;
      logic     count_dec;
      logic     scan_start;
      logic     scan_run;
      logic     shift_start;
      logic     shift_run;
      logic     pend_set;
      pend_type pend_kind;
      logic     rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   scan_done;
      logic   found;
      logic   shift_done;
      logic   out_free;
   } stat_type;

endpackage

FILE: sv/rq_ram.sv
// ----------------------------------------------------------------------------
// rq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rq_ram #(
   parameter int WIDTH = rq_pkg::ENTRY_W,
   parameter int DEPTH = rq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/rq_ctrl.sv
// ----------------------------------------------------------------------------
// rq_ctrl: ready queue sequencer
// Accepts one request, steps the datapath through decide, scan and
// close-up, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rq_pkg::stat_type  stat,
   output rq_pkg::cmd_type   cmd
);
   import rq_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.op == OP_INSERT || stat.empty) state_in = ST_DONE;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               if (!stat.found || stat.op == OP_PEEK) state_in = ST_DONE;
               else state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (stat.shift_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.pend_kind = PEND_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_DECIDE: begin
            if (stat.op == OP_INSERT) begin
               cmd.pend_set = 1'b1;
               if (stat.full) begin
                  cmd.pend_kind = PEND_FULL;
               end else begin
                  cmd.pend_kind = PEND_NEW;
                  cmd.ins_write = 1'b1;
               end
            end else if (stat.empty) begin
               cmd.pend_set  = 1'b1;
               cmd.pend_kind = PEND_NONE;
            end else begin
               cmd.scan_start = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               cmd.pend_set = 1'b1;
               if (!stat.found) begin
                  cmd.pend_kind = PEND_NONE;
               end else begin
                  cmd.pend_kind   = PEND_BEST;
                  cmd.shift_start = (stat.op != OP_PEEK);
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            cmd.count_dec = stat.shift_done;
         end
         ST_DONE: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
            cmd.pend_kind = PEND_NONE;
         end
      endcase
   end

endmodule

FILE: sv/rq_dpath.sv
// ----------------------------------------------------------------------------
// rq_dpath: ready queue datapath
// Entry RAM, fill count, id counter, scan and close-up pointers, the
// pending result and the output register.
// ----------------------------------------------------------------------------
module rq_dpath #(
   parameter int QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rq_pkg::cmd_type             cmd,
   output rq_pkg::stat_type            stat,
   input  logic                        csr_valid,
   input  logic                        csr_data,
   input  logic [1:0]                  req_op,
   input  logic [rq_pkg::PRIO_W-1:0]   req_prio,
   input  logic [rq_pkg::TAG_W-1:0]    req_tag,
   input  logic [rq_pkg::ID_W-1:0]     req_job_id,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rq_pkg::STAT_W-1:0]   rsp_status,
   output logic [rq_pkg::ENTRY_W-1:0]  rsp_entry
);
   import rq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request latch
   op_type            op_ff, op_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [ID_W-1:0]   jobid_ff, jobid_in;

   // queue state
   logic              policy_ff, policy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;

   // scan
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   entry_type         best_ff, best_in;

   // close-up
   logic [CNT_W-1:0]  sh_ff, sh_in;
   logic              wr_vld_ff, wr_vld_in;
   logic [IDX_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0]  sh_back;

   // pending and output results
   logic [STAT_W-1:0] pend_stat_ff, pend_stat_in;
   entry_type         pend_ff, pend_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   entry_type         rsp_ff, rsp_in;

   // RAM ports
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry;
   entry_type           new_entry;
   logic                take;
   logic                issue_scan;
   logic                issue_sh;

   rq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry  = ram_rdata;
   assign new_entry = '{tag: tag_ff, prio: prio_ff, id: next_id_ff};
   assign sh_back   = sh_ff - CNT_W'(1);

   // RAM port steering: insert at the tail, close-up writes one slot back
   always_comb begin
      ram_we    = cmd.ins_write | wr_vld_ff;
      ram_waddr = cmd.ins_write ? count_ff[IDX_W-1:0] : wr_addr_ff;
      ram_wdata = cmd.ins_write ? new_entry : ram_rdata;
      ram_raddr = cmd.shift_run ? sh_ff[IDX_W-1:0] : scan_ff[IDX_W-1:0];
   end

   // selection rule for the entry coming back from the RAM
   always_comb begin
      take = 1'b0;
      if (chk_vld_ff) begin
         if (op_ff == OP_REMOVE) take = !found_ff && (rd_entry.id == jobid_ff);
         else if (op_ff == OP_POP && !policy_ff) take = !found_ff;
         else take = !found_ff || (rd_entry.prio < best_ff.prio);
      end
   end

   assign issue_scan = scan_ff < count_ff;
   assign issue_sh   = sh_ff < count_ff;

   // next values
   always_comb begin
      op_in        = op_ff;
      prio_in      = prio_ff;
      tag_in       = tag_ff;
      jobid_in     = jobid_ff;
      policy_in    = policy_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      scan_in      = scan_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      sh_in        = sh_ff;
      wr_vld_in    = wr_vld_ff;
      wr_addr_in   = wr_addr_ff;
      pend_stat_in = pend_stat_ff;
      pend_in      = pend_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_in       = rsp_ff;

      if (csr_valid) policy_in = csr_data;

      if (cmd.load_req) begin
         op_in    = op_type'(req_op);
         prio_in  = req_prio;
         tag_in   = req_tag;
         jobid_in = req_job_id;
      end

      if (cmd.ins_write) begin
         count_in   = count_ff + CNT_W'(1);
         next_id_in = next_id_ff + ID_W'(1);
      end
      if (cmd.count_dec) count_in = count_ff - CNT_W'(1);

      // scan: one read issued and one entry checked per cycle
      if (cmd.scan_start) begin
         scan_in    = '0;
         chk_vld_in = 1'b0;
         found_in   = 1'b0;
      end
      if (cmd.scan_run) begin
         if (issue_scan) scan_in = scan_ff + CNT_W'(1);
         chk_vld_in = issue_scan;
         chk_idx_in = scan_ff[IDX_W-1:0];
         if (take) begin
            found_in    = 1'b1;
            best_idx_in = chk_idx_ff;
            best_in     = rd_entry;
         end
      end

      // close-up: read slot i+1, write it to slot i next cycle
      if (cmd.shift_start) begin
         sh_in     = CNT_W'(best_idx_ff) + CNT_W'(1);
         wr_vld_in = 1'b0;
      end
      if (cmd.shift_run) begin
         if (issue_sh) sh_in = sh_ff + CNT_W'(1);
         wr_vld_in  = issue_sh;
         wr_addr_in = sh_back[IDX_W-1:0];
      end

      if (cmd.pend_set) begin
         case (cmd.pend_kind)
            PEND_NEW: begin
               pend_stat_in = STAT_OK;
               pend_in      = new_entry;
            end
            PEND_FULL: begin
               pend_stat_in = STAT_FULL;
               pend_in      = '0;
            end
            PEND_BEST: begin
               pend_stat_in = STAT_OK;
               pend_in      = best_ff;
            end
            default: begin
               pend_stat_in = STAT_NONE;
               pend_in      = '0;
            end
         endcase
      end

      // output register
      if (cmd.rsp_load) begin
         rsp_vld_in  = 1'b1;
         rsp_stat_in = pend_stat_ff;
         rsp_in      = pend_ff;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= 1'b0;
         count_ff   <= '0;
         next_id_ff <= '0;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         sh_ff      <= '0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         op_ff      <= OP_INSERT;
      end else begin
         policy_ff  <= policy_in;
         count_ff   <= count_in;
         next_id_ff <= next_id_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         found_ff   <= found_in;
         sh_ff      <= sh_in;
         wr_vld_ff  <= wr_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         op_ff      <= op_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prio_ff      <= prio_in;
      tag_ff       <= tag_in;
      jobid_ff     <= jobid_in;
      chk_idx_ff   <= chk_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      wr_addr_ff   <= wr_addr_in;
      pend_stat_ff <= pend_stat_in;
      pend_ff      <= pend_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_ff       <= rsp_in;
   end

   // status to the controller
   always_comb begin
      stat.op         = op_ff;
      stat.full       = count_ff == CNT_W'(QUEUE_DEPTH);
      stat.empty      = count_ff == '0;
      stat.scan_done  = !issue_scan && !chk_vld_ff;
      stat.found      = found_ff;
      stat.shift_done = !issue_sh && !wr_vld_ff;
      stat.out_free   = !rsp_vld_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_entry  = rsp_ff;

endmodule

FILE: sv/ready_queue_fifo_or_priority.sv
// ----------------------------------------------------------------------------
// ready_queue_fifo_or_priority: job ready queue, FIFO or priority order
// Insert, pop by policy, peek best priority and remove by id over a queue
// kept in arrival order.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser op, tdata prio/tag/job_id
//   rsp      out  rsp_tvalid/rsp_tready  tuser status, tdata id/prio/tag
//   csr      in   csr_valid/csr_ready    csr_data policy_mode (0 FIFO)
//
// One request at a time. Insert and any request on an empty queue skip
// the scan; pop, peek and remove scan the N held entries one by one
// through the single RAM read port. A pop or a remove that takes a job
// out then closes up, moving each job behind it one slot forward.
// Reset is synchronous and needs no clearing pass. A result waits in the
// output register while the next request is taken; the block stalls only
// when a second result is ready.
// ----------------------------------------------------------------------------
module ready_queue_fifo_or_priority #(
   parameter int QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,     // policy_mode
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] op
   input  logic [39:0] req_tdata,    // [7:0] priority_req, [23:8] control_tag,
                                     // [39:24] job_id
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,    // [1:0] status
   output logic [39:0] rsp_tdata     // [15:0] out_id, [23:16] out_priority,
                                     // [39:24] out_tag
);
   import rq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // configuration is always accepted
   assign csr_ready = 1'b1;

   rq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_op     (req_tuser),
      .req_prio   (req_tdata[7:0]),
      .req_tag    (req_tdata[23:8]),
      .req_job_id (req_tdata[39:24]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_entry  (rsp_tdata)
   );

endmodule
